[rtl/kmer_hit_hotspot_seeder_macros.svh]
// assertion macros for the hotspot seeder
`ifndef KMER_HIT_HOTSPOT_SEEDER_MACROS_SVH
`define KMER_HIT_HOTSPOT_SEEDER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("khs assertion failed");
// next-cycle implication
`define KHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("khs assertion failed");
`else
`define KHS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/khs_pkg.sv]
package khs_pkg;

  localparam int SEED_DEPTH    = 512;
  localparam int POSITION_BITS = 32;
  localparam int KMER_LENGTH   = 31;

  localparam int POS_W   = POSITION_BITS;
  localparam int SEED_W  = 10;
  localparam int RING_AW = (SEED_DEPTH > 1) ? $clog2(SEED_DEPTH) : 1;
  localparam int CNT_W   = $clog2(SEED_DEPTH + 1);

  // register indexes on the config port
  localparam logic [1:0] REG_SEED_COUNT   = 2'd0;
  localparam logic [1:0] REG_WINDOW_BASES = 2'd1;
  localparam logic [1:0] REG_MERGE_GAP    = 2'd2;
  localparam logic [1:0] REG_REGION_END   = 2'd3;

  // input commands
  localparam logic CMD_HIT   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // word held between the ring stage and the hotspot stage
  typedef struct packed {
    logic             flush;
    logic [POS_W-1:0] newest;
    logic [POS_W-1:0] seed_hi;
    logic             fill_ok;
    logic             self_oldest;
  } khs_item_t;

endpackage

[rtl/khs_ring_mem.sv]
module khs_ring_mem
  import khs_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [RING_AW-1:0] waddr_i,
  input  logic [POS_W-1:0]   wdata_i,
  input  logic               re_i,
  input  logic [RING_AW-1:0] raddr_i,
  output logic [POS_W-1:0]   rdata_o
);

  logic [POS_W-1:0] mem_q [SEED_DEPTH];
  logic [POS_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/khs_hotspot.sv]
module khs_hotspot
  import khs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  khs_item_t        item_i,
  input  logic [POS_W-1:0] ring_data_i,
  input  logic [31:0]      window_bases_i,
  input  logic [31:0]      merge_gap_i,
  output logic             item_done_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [POS_W-1:0] out_start_o,
  output logic [POS_W-1:0] out_end_o
);

  logic             open_q, open_d;
  logic [POS_W-1:0] open_start_q, open_start_d;
  logic [POS_W-1:0] open_end_q, open_end_d;
  logic             out_valid_q, out_valid_d;
  logic [POS_W-1:0] out_start_q, out_end_q;

  logic [POS_W-1:0] oldest;
  logic [POS_W-1:0] span;
  logic [POS_W-1:0] gap;
  logic             seed_ok;
  logic             merge;
  logic             emit;
  logic             out_free;
  logic             done;

  always_comb begin
    oldest   = item_i.self_oldest ? item_i.newest : ring_data_i;
    span     = item_i.newest - oldest;
    seed_ok  = item_i.fill_ok && (item_i.newest >= oldest) && (span < window_bases_i);
    gap      = oldest - open_end_q;
    merge    = open_q && ((oldest <= open_end_q) || (gap <= merge_gap_i));
    if (item_i.flush) begin
      emit = open_q;
    end else begin
      emit = seed_ok && !merge && open_q;
    end
    out_free = !out_valid_q || out_ready_i;
    done     = item_valid_i && (!emit || out_free);
  end

  always_comb begin
    open_d       = open_q;
    open_start_d = open_start_q;
    open_end_d   = open_end_q;
    if (done) begin
      if (item_i.flush) begin
        open_d       = 1'b0;
        open_start_d = '0;
        open_end_d   = '0;
      end else if (seed_ok) begin
        if (merge) begin
          if (item_i.seed_hi > open_end_q) begin
            open_end_d = item_i.seed_hi;
          end
        end else begin
          open_d       = 1'b1;
          open_start_d = oldest;
          open_end_d   = item_i.seed_hi;
        end
      end
    end
  end

  always_comb begin
    if (done && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= 1'b0;
      open_start_q <= '0;
      open_end_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      open_q       <= open_d;
      open_start_q <= open_start_d;
      open_end_q   <= open_end_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && emit) begin
      out_start_q <= open_start_q;
      out_end_q   <= open_end_q;
    end
  end

  assign item_done_o = done;
  assign out_valid_o = out_valid_q;
  assign out_start_o = out_start_q;
  assign out_end_o   = out_end_q;

endmodule

[rtl/kmer_hit_hotspot_seeder.sv]
// k-mer hit hotspot seeder
// input channel: in_valid_i/in_ready_o carry one word of command and position;
//   a hit word writes its position into the hit ring, a flush word emits the
//   open hotspot (if any) and clears ring and hotspot state
// output channel: out_valid_o/out_ready_i carry one finished hotspot
//   (start inclusive, end exclusive and clamped to region_end)
// config port: cfg_we_i writes cfg_data_i into the register picked by cfg_index_i
//   (seed_count, window_bases, merge_gap, region_end); the user writes only while idle, not enforced
// timing: one word per cycle while the hotspot stage is not stalled; a word is
//   taken into the ring stage, where the oldest hit of the window is read from
//   the ring memory port, then the hotspot stage compares and merges; the result
//   closed by a word is held in the output register
// stall: the output register holds a waiting result; the hotspot stage keeps
//   working on words that produce no result and only stops on a word that must
//   emit while the output is full; the input stalls only behind that stage
// reset: registers go to their reset values, ring and hotspot are empty;
//   ring contents are never used before written, so no clearing pass is needed
module kmer_hit_hotspot_seeder
  import khs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_command_i,
  input  logic [POS_W-1:0] in_position_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [POS_W-1:0] out_hotspot_start_o,
  output logic [POS_W-1:0] out_hotspot_end_o
);

`include "kmer_hit_hotspot_seeder_macros.svh"

  // config registers
  logic [SEED_W-1:0] seed_count_q;
  logic [31:0]       window_bases_q;
  logic [31:0]       merge_gap_q;
  logic [31:0]       region_end_q;

  // ring bookkeeping
  logic [RING_AW-1:0] head_q, head_d;
  logic [CNT_W-1:0]   fill_q, fill_d;

  // word between ring stage and hotspot stage
  logic      s1_valid_q, s1_valid_d;
  khs_item_t s1_item_q, s1_item_d;

  logic              accept;
  logic              hit;
  logic              s1_done;
  logic [CNT_W-1:0]  need;
  logic [CNT_W-1:0]  fill_next;
  logic [CNT_W:0]    head_plus;
  logic [CNT_W:0]    raddr_w;
  logic [RING_AW-1:0] raddr;
  logic [POS_W:0]    end_sum;
  logic [POS_W-1:0]  ring_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_count_q   <= SEED_W'(500);
      window_bases_q <= 32'd1000;
      merge_gap_q    <= 32'd500;
      region_end_q   <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SEED_COUNT:   seed_count_q   <= cfg_data_i[SEED_W-1:0];
        REG_WINDOW_BASES: window_bases_q <= cfg_data_i;
        REG_MERGE_GAP:    merge_gap_q    <= cfg_data_i;
        REG_REGION_END:   region_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !s1_valid_q || s1_done;
  assign accept     = in_valid_i && in_ready_o;
  assign hit        = accept && (in_command_i == CMD_HIT);

  // ring stage: seed size, fill check, oldest slot, clamped seed end
  always_comb begin
    // zero seed count acts as one, oversize saturates at the ring depth
    if (seed_count_q == '0) begin
      need = CNT_W'(1);
    end else if (32'(seed_count_q) > 32'(SEED_DEPTH)) begin
      need = CNT_W'(SEED_DEPTH);
    end else begin
      need = CNT_W'(seed_count_q);
    end

    if (fill_q < CNT_W'(SEED_DEPTH)) begin
      fill_next = fill_q + CNT_W'(1);
    end else begin
      fill_next = fill_q;
    end

    // oldest hit of the window sits need-1 slots behind the one written now
    head_plus = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(1);
    if (head_plus >= (CNT_W + 1)'(need)) begin
      raddr_w = head_plus - (CNT_W + 1)'(need);
    end else begin
      raddr_w = head_plus + (CNT_W + 1)'(SEED_DEPTH) - (CNT_W + 1)'(need);
    end
    raddr = raddr_w[RING_AW-1:0];

    end_sum = (POS_W + 1)'(in_position_i) + (POS_W + 1)'(KMER_LENGTH);

    s1_item_d.flush       = (in_command_i == CMD_FLUSH);
    s1_item_d.newest      = in_position_i;
    s1_item_d.fill_ok     = (fill_next >= need);
    // a one-hit window reads the slot being written: take the new position
    s1_item_d.self_oldest = (need == CNT_W'(1));
    if (end_sum > (POS_W + 1)'(region_end_q)) begin
      s1_item_d.seed_hi = region_end_q;
    end else begin
      s1_item_d.seed_hi = end_sum[POS_W-1:0];
    end
  end

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (accept) begin
      if (in_command_i == CMD_FLUSH) begin
        head_d = '0;
        fill_d = '0;
      end else begin
        if (head_q == RING_AW'(SEED_DEPTH - 1)) begin
          head_d = '0;
        end else begin
          head_d = head_q + RING_AW'(1);
        end
        fill_d = fill_next;
      end
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      fill_q     <= fill_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= s1_item_d;
    end
  end

  khs_ring_mem u_ring (
    .clk_i   (clk_i),
    .we_i    (hit),
    .waddr_i (head_q),
    .wdata_i (in_position_i),
    .re_i    (hit),
    .raddr_i (raddr),
    .rdata_o (ring_data)
  );

  khs_hotspot u_hotspot (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (s1_valid_q),
    .item_i         (s1_item_q),
    .ring_data_i    (ring_data),
    .window_bases_i (window_bases_q),
    .merge_gap_i    (merge_gap_q),
    .item_done_o    (s1_done),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_start_o    (out_hotspot_start_o),
    .out_end_o      (out_hotspot_end_o)
  );

  // ring bookkeeping stays in range
  `KHS_ASSERT_NOW(a_fill_range, clk_i, rst_ni, 1'b1, fill_q <= CNT_W'(SEED_DEPTH))
  `KHS_ASSERT_NOW(a_head_range, clk_i, rst_ni, 1'b1, head_q <= RING_AW'(SEED_DEPTH - 1))
  // a flush word empties the ring
  `KHS_ASSERT_NEXT(a_flush_clears, clk_i, rst_ni, accept && (in_command_i == CMD_FLUSH), (fill_q == '0) && (head_q == '0))
  // the input only stalls behind a hotspot stage blocked by a full output
  `KHS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o, s1_valid_q && out_valid_o && !out_ready_i)

endmodule
